FILE: rtl/roi_np_pkg.sv
// Shared widths, register indexes and the arctangent table of the nearest-point block.
`timescale 1ns / 1ps

package roi_np_pkg;

	localparam int COL_W    = 11;
	localparam int ROW_W    = 10;
	localparam int COORD_W  = 16;
	localparam int DIST_W   = 32;
	localparam int RANGE_W  = 16;
	localparam int BEAR_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// CORDIC datapath: 17-bit magnitude after the half turn, scaled by 256,
	// plus headroom for the CORDIC gain.
	localparam int CX_W      = 27;
	localparam int ANG_W     = 21;
	localparam int TAB_IDX_W = 5;

	localparam int PI_Q16 = 205887;
	localparam int PI_Q13 = 25736;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_MAX = 3'd4;

	// atan(2^-i) in Q16 radians, rounded to nearest.
	function automatic logic [ANG_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
		logic [ANG_W-1:0] t;
		case (idx)
			5'd0:  t = 21'd51472;
			5'd1:  t = 21'd30386;
			5'd2:  t = 21'd16055;
			5'd3:  t = 21'd8150;
			5'd4:  t = 21'd4091;
			5'd5:  t = 21'd2047;
			5'd6:  t = 21'd1024;
			5'd7:  t = 21'd512;
			5'd8:  t = 21'd256;
			5'd9:  t = 21'd128;
			5'd10: t = 21'd64;
			5'd11: t = 21'd32;
			5'd12: t = 21'd16;
			5'd13: t = 21'd8;
			5'd14: t = 21'd4;
			5'd15: t = 21'd2;
			5'd16: t = 21'd1;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/roi_np_dist.sv
// Squared 3-D range through one shared 16x16 multiplier over three passes.
`timescale 1ns / 1ps

module roi_np_dist (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [roi_np_pkg::COORD_W-1:0] x,
	input  logic signed [roi_np_pkg::COORD_W-1:0] y,
	input  logic signed [roi_np_pkg::COORD_W-1:0] z,
	output logic                                 busy,
	output logic        [roi_np_pkg::DIST_W-1:0]  sum_sq
);

	logic                                  busy_q;
	logic [1:0]                            cnt_q;
	logic signed [roi_np_pkg::COORD_W-1:0] op;
	logic signed [roi_np_pkg::DIST_W-1:0]  sq;
	logic [roi_np_pkg::DIST_W-1:0]         prod_q;
	logic [roi_np_pkg::DIST_W-1:0]         acc_q;

	// The operand walks x, y, z; each product is registered and added in the cycle after.
	always_comb begin
		case (cnt_q)
			2'd0:    op = x;
			2'd1:    op = y;
			default: op = z;
		endcase
		sq = op * op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			prod_q <= sq;
			if (cnt_q == 2'd0) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + prod_q;
			end
		end
	end

	assign busy   = busy_q;
	assign sum_sq = acc_q;

endmodule

FILE: rtl/roi_np_isqrt.sv
// Integer square root, one result bit per cycle with a shared add and compare.
`timescale 1ns / 1ps

module roi_np_isqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [roi_np_pkg::DIST_W-1:0]       value,
	output logic                                busy,
	output logic [roi_np_pkg::RANGE_W-1:0]      root
);

	localparam int W = roi_np_pkg::DIST_W;

	logic         busy_q;
	logic [W-1:0] v_q;
	logic [W-1:0] r_q;
	logic [W-1:0] one_q;
	logic [W:0]   trial;
	logic         take;

	assign trial = {1'b0, r_q} + {1'b0, one_q};
	assign take  = {1'b0, v_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && one_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			one_q <= {2'b01, {(W-2){1'b0}}};
		end else if (busy_q) begin
			if (take) begin
				v_q <= v_q - trial[W-1:0];
				r_q <= (r_q >> 1) + one_q;
			end else begin
				r_q <= r_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[roi_np_pkg::RANGE_W-1:0];

endmodule

FILE: rtl/roi_np_cordic.sv
// Vectoring CORDIC for the bearing, one micro-rotation per cycle.
`timescale 1ns / 1ps

module roi_np_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [roi_np_pkg::COORD_W-1:0]  x,
	input  logic signed [roi_np_pkg::COORD_W-1:0]  y,
	output logic                                  busy,
	output logic signed [roi_np_pkg::BEAR_W-1:0]   bearing
);

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [IW-1:0] LAST = IW'(STEPS - 1);
	localparam int CX_W  = roi_np_pkg::CX_W;
	localparam int ANG_W = roi_np_pkg::ANG_W;
	localparam int MAG_W = roi_np_pkg::COORD_W + 1;

	logic                    busy_q;
	logic [IW-1:0]           i_q;
	logic signed [CX_W-1:0]  x_q;
	logic signed [CX_W-1:0]  y_q;
	logic signed [ANG_W-1:0] a_q;
	logic                    zero_q;
	logic signed [roi_np_pkg::BEAR_W-1:0] bearing_q;

	logic                     neg;
	logic signed [MAG_W-1:0]  xe;
	logic signed [MAG_W-1:0]  ye;
	logic signed [MAG_W-1:0]  xn;
	logic signed [MAG_W-1:0]  yn;
	logic signed [ANG_W-1:0]  a0;
	logic signed [CX_W-1:0]   dx;
	logic signed [CX_W-1:0]   dy;
	logic signed [ANG_W-1:0]  t;
	logic signed [CX_W-1:0]   x_nx;
	logic signed [CX_W-1:0]   y_nx;
	logic signed [ANG_W-1:0]  a_nx;
	logic signed [ANG_W-1:0]  b_full;
	logic signed [ANG_W-1:0]  b_clamp;

	// A vector in the left half plane is turned by half a turn first.
	always_comb begin
		neg = x[roi_np_pkg::COORD_W-1];
		xe  = {x[roi_np_pkg::COORD_W-1], x};
		ye  = {y[roi_np_pkg::COORD_W-1], y};
		xn  = neg ? -xe : xe;
		yn  = neg ? -ye : ye;
		if (!neg) begin
			a0 = '0;
		end else if (y[roi_np_pkg::COORD_W-1]) begin
			a0 = -ANG_W'(roi_np_pkg::PI_Q16);
		end else begin
			a0 = ANG_W'(roi_np_pkg::PI_Q16);
		end
	end

	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		t  = roi_np_pkg::atan_q16(roi_np_pkg::TAB_IDX_W'(i_q));
		if (y_q > 0) begin
			x_nx = x_q + dx;
			y_nx = y_q - dy;
			a_nx = a_q + t;
		end else begin
			x_nx = x_q - dx;
			y_nx = y_q + dy;
			a_nx = a_q - t;
		end
		// Q16 to Q2.13 with rounding, then clamp to plus or minus pi.
		b_full = (a_nx + ANG_W'(4)) >>> 3;
		if (b_full > ANG_W'(roi_np_pkg::PI_Q13)) begin
			b_clamp = ANG_W'(roi_np_pkg::PI_Q13);
		end else if (b_full < -ANG_W'(roi_np_pkg::PI_Q13)) begin
			b_clamp = -ANG_W'(roi_np_pkg::PI_Q13);
		end else begin
			b_clamp = b_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + IW'(1);
			if (i_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= {{(CX_W-MAG_W-8){xn[MAG_W-1]}}, xn, 8'h00};
			y_q    <= {{(CX_W-MAG_W-8){yn[MAG_W-1]}}, yn, 8'h00};
			a_q    <= a0;
			zero_q <= (x == '0) && (y == '0);
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			a_q <= a_nx;
			if (i_q == LAST) begin
				bearing_q <= zero_q ? '0 : b_clamp[roi_np_pkg::BEAR_W-1:0];
			end
		end
	end

	assign busy    = busy_q;
	assign bearing = bearing_q;

endmodule

FILE: rtl/roi_nearest_point_polar_top.sv
// Top level: box filter, nearest-point tracking and polar result sequencer.
`timescale 1ns / 1ps

//  Channel | Handshake            | Beat contents
//  --------+----------------------+------------------------------------------------
//  point   | pt_valid / pt_stall  | pixel_col, pixel_row, point_x/y/z, point_valid,
//          |                      | frame_end
//  result  | res_valid/ res_stall | near_x, near_y, near_range, near_bearing, found
//  config  | cfg_we               | cfg_index, cfg_data (no wait, no read-back)
//
//  A point beat that is disabled or outside the box and not a frame end leaves the
//  sequencer in S_IDLE. A point inside the box holds it in S_DIST while the shared
//  multiplier squares x, y and z in turn and the accumulator compares the sum against
//  the best so far. A frame end that found a point then passes S_FIN, S_POLAR, where
//  the bit-serial square root and the CORDIC loop run side by side, and S_OUT, where
//  the result register is loaded; an empty frame goes from S_FIN straight to S_OUT.
//  arst_n clears the sequencer, the accumulator and all box registers.
//  pt_stall is high while a beat is being worked on; a result that waits on
//  res_stall holds the block only when the next result is ready to be loaded.

module roi_nearest_point_polar_top #(
	parameter int MAX_COLS     = 2048,
	parameter int MAX_ROWS     = 1024,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,

	input  logic                                    cfg_we,
	input  logic        [roi_np_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [roi_np_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                                    pt_valid,
	output logic                                    pt_stall,
	input  logic        [roi_np_pkg::COL_W-1:0]      pixel_col,
	input  logic        [roi_np_pkg::ROW_W-1:0]      pixel_row,
	input  logic signed [roi_np_pkg::COORD_W-1:0]    point_x,
	input  logic signed [roi_np_pkg::COORD_W-1:0]    point_y,
	input  logic signed [roi_np_pkg::COORD_W-1:0]    point_z,
	input  logic                                    point_valid,
	input  logic                                    frame_end,

	output logic                                    res_valid,
	input  logic                                    res_stall,
	output logic signed [roi_np_pkg::COORD_W-1:0]    near_x,
	output logic signed [roi_np_pkg::COORD_W-1:0]    near_y,
	output logic        [roi_np_pkg::RANGE_W-1:0]    near_range,
	output logic signed [roi_np_pkg::BEAR_W-1:0]     near_bearing,
	output logic                                    found
);

	localparam int COL_W   = roi_np_pkg::COL_W;
	localparam int ROW_W   = roi_np_pkg::ROW_W;
	localparam int COORD_W = roi_np_pkg::COORD_W;
	localparam int DIST_W  = roi_np_pkg::DIST_W;
	localparam int COL_LIM_W = ($clog2(MAX_COLS + 1) > COL_W) ? $clog2(MAX_COLS + 1) : COL_W;
	localparam int ROW_LIM_W = ($clog2(MAX_ROWS + 1) > ROW_W) ? $clog2(MAX_ROWS + 1) : ROW_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIST,
		S_FIN,
		S_POLAR,
		S_OUT
	} state_t;

	// Box registers.
	logic             box_enable_q;
	logic [COL_W-1:0] box_col_min_q;
	logic [COL_W-1:0] box_col_max_q;
	logic [ROW_W-1:0] box_row_min_q;
	logic [ROW_W-1:0] box_row_max_q;

	state_t state_q;

	// The point under work is held here while the multiplier passes run.
	logic signed [COORD_W-1:0] px_q;
	logic signed [COORD_W-1:0] py_q;
	logic signed [COORD_W-1:0] pz_q;
	logic                      fend_q;

	// Running best of the frame.
	logic [DIST_W-1:0]         best_dist_q;
	logic signed [COORD_W-1:0] best_x_q;
	logic signed [COORD_W-1:0] best_y_q;
	logic                      seen_any_q;

	// Snapshot of the best point taken at frame end, kept for the result beat.
	logic signed [COORD_W-1:0] cap_x_q;
	logic signed [COORD_W-1:0] cap_y_q;
	logic                      cap_found_q;

	logic                           res_valid_q;
	logic signed [COORD_W-1:0]      near_x_q;
	logic signed [COORD_W-1:0]      near_y_q;
	logic [roi_np_pkg::RANGE_W-1:0] near_range_q;
	logic signed [roi_np_pkg::BEAR_W-1:0] near_bearing_q;
	logic                           found_q;

	logic                           pt_acc;
	logic                           in_box;
	logic                           dist_start;
	logic                           dist_busy;
	logic [DIST_W-1:0]              sum_sq;
	logic                           polar_start;
	logic                           sq_busy;
	logic [roi_np_pkg::RANGE_W-1:0] sq_root;
	logic                           cd_busy;
	logic signed [roi_np_pkg::BEAR_W-1:0] cd_bearing;
	logic                           res_free;

	assign pt_stall = (state_q != S_IDLE);
	assign pt_acc   = pt_valid && !pt_stall;
	assign res_free = !res_valid_q || !res_stall;

	// Columns are exclusive at both bounds, rows inclusive; anything past the
	// frame geometry never counts.
	assign in_box = point_valid &&
		(COL_LIM_W'(pixel_col) < COL_LIM_W'(MAX_COLS)) &&
		(ROW_LIM_W'(pixel_row) < ROW_LIM_W'(MAX_ROWS)) &&
		(pixel_col > box_col_min_q) && (pixel_col < box_col_max_q) &&
		(pixel_row >= box_row_min_q) && (pixel_row <= box_row_max_q);

	assign dist_start  = pt_acc && box_enable_q && in_box;
	assign polar_start = (state_q == S_FIN) && seen_any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_enable_q  <= 1'b0;
			box_col_min_q <= '0;
			box_col_max_q <= '0;
			box_row_min_q <= '0;
			box_row_max_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				roi_np_pkg::CFG_ENABLE:  box_enable_q  <= cfg_data[0];
				roi_np_pkg::CFG_COL_MIN: box_col_min_q <= cfg_data[COL_W-1:0];
				roi_np_pkg::CFG_COL_MAX: box_col_max_q <= cfg_data[COL_W-1:0];
				roi_np_pkg::CFG_ROW_MIN: box_row_min_q <= cfg_data[ROW_W-1:0];
				roi_np_pkg::CFG_ROW_MAX: box_row_max_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Point latch for the multiplier; it only loads on an accepted beat.
	always_ff @(posedge clk) begin
		if (pt_acc) begin
			px_q   <= point_x;
			py_q   <= point_y;
			pz_q   <= point_z;
			fend_q <= frame_end;
		end
	end

	// Sequencer, accumulator and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			best_dist_q  <= '1;
			best_x_q     <= '0;
			best_y_q     <= '0;
			seen_any_q   <= 1'b0;
			cap_x_q      <= '0;
			cap_y_q      <= '0;
			cap_found_q  <= 1'b0;
			res_valid_q  <= 1'b0;
			near_x_q     <= '0;
			near_y_q     <= '0;
			near_range_q <= '0;
			near_bearing_q <= '0;
			found_q      <= 1'b0;
		end else begin
			// While a new result is loaded the valid flag is set below instead.
			if (res_valid_q && !res_stall && (state_q != S_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pt_acc) begin
						if (!box_enable_q) begin
							// A disabled frame end only drops what was gathered.
							if (frame_end) begin
								best_dist_q <= '1;
								best_x_q    <= '0;
								best_y_q    <= '0;
								seen_any_q  <= 1'b0;
							end
						end else if (in_box) begin
							state_q <= S_DIST;
						end else if (frame_end) begin
							state_q <= S_FIN;
						end
					end
				end
				S_DIST: begin
					if (!dist_busy) begin
						// Strict compare keeps the earlier point on a tie.
						if (!seen_any_q || (sum_sq < best_dist_q)) begin
							best_dist_q <= sum_sq;
							best_x_q    <= px_q;
							best_y_q    <= py_q;
							seen_any_q  <= 1'b1;
						end
						state_q <= fend_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					// The square root and CORDIC units latch the best point now,
					// so the accumulator is free for the next frame.
					cap_x_q     <= best_x_q;
					cap_y_q     <= best_y_q;
					cap_found_q <= seen_any_q;
					best_dist_q <= '1;
					best_x_q    <= '0;
					best_y_q    <= '0;
					seen_any_q  <= 1'b0;
					state_q     <= seen_any_q ? S_POLAR : S_OUT;
				end
				S_POLAR: begin
					if (!sq_busy && !cd_busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						found_q     <= cap_found_q;
						if (cap_found_q) begin
							near_x_q       <= cap_x_q;
							near_y_q       <= cap_y_q;
							near_range_q   <= sq_root;
							near_bearing_q <= cd_bearing;
						end else begin
							near_x_q       <= '0;
							near_y_q       <= '0;
							near_range_q   <= '0;
							near_bearing_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	roi_np_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.x      (px_q),
		.y      (py_q),
		.z      (pz_q),
		.busy   (dist_busy),
		.sum_sq (sum_sq)
	);

	roi_np_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (polar_start),
		.value  (best_dist_q),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	roi_np_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (polar_start),
		.x       (best_x_q),
		.y       (best_y_q),
		.busy    (cd_busy),
		.bearing (cd_bearing)
	);

	assign res_valid    = res_valid_q;
	assign near_x       = near_x_q;
	assign near_y       = near_y_q;
	assign near_range   = near_range_q;
	assign near_bearing = near_bearing_q;
	assign found        = found_q;

	// An empty frame reports all-zero fields.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !found) |-> (near_x == '0 && near_y == '0 &&
			near_range == '0 && near_bearing == '0))
		else $error("empty frame result carries nonzero fields");

	// A point at the origin in x and y has zero bearing.
	a_origin_bearing: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && found && near_x == '0 && near_y == '0) |-> (near_bearing == '0))
		else $error("origin point with nonzero bearing");

	// The accumulator is at its cleared value whenever nothing has been seen.
	a_clear_dist: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_any_q |-> (best_dist_q == '1))
		else $error("accumulator not cleared");

	// A beat taken while disabled never starts the datapath.
	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_acc && !box_enable_q) |=> (state_q == S_IDLE && !dist_busy))
		else $error("disabled beat started work");

	// Both polar units are idle whenever the result is being loaded.
	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (!sq_busy && !cd_busy))
		else $error("result loaded while polar units still run");

endmodule

FILE: bench/roi_nearest_point_polar_tb.sv
// Self-checking bench for the nearest in-box point block with its polar result.
`timescale 1ns / 1ps

module tb;

	import roi_np_pkg::*;

	// Block parameters, shared between the instance and the predictor.
	localparam int MAX_COLS     = 2048;
	localparam int MAX_ROWS     = 1024;
	localparam int CORDIC_STEPS = 16;

	// The last point of a frame can still pass through the box stage and then the
	// square root and CORDIC. The settle pause is comfortably longer than all of
	// that, so a register write never lands on work in flight.
	localparam int SETTLE_CYCLES = 60;
	localparam int LONG_HOLD     = 400;
	localparam int LIMIT         = 300000;

	// atan(2^-i) in Q16 radians, rounded to nearest.
	localparam longint ARC_Q16 [24] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2,
		1, 0, 0, 0, 0, 0, 0, 0
	};

	typedef struct {
		logic [COL_W-1:0]          col;
		logic [ROW_W-1:0]          row;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      valid;
		logic                      fend;
	} point_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [RANGE_W-1:0]        reach;
		logic signed [BEAR_W-1:0]  heading;
		logic                      hit;
	} polar_t;

	// Floor of the square root, one result bit per pass.
	function automatic longint root_floor(longint v);
		longint r, probe;
		r = 0;
		probe = 64'sd1 <<< 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= r + probe) begin
				v = v - (r + probe);
				r = (r >> 1) + probe;
			end else begin
				r = r >> 1;
			end
			probe = probe >> 2;
		end
		return r;
	endfunction

	// Vectoring CORDIC bearing in Q2.13; arithmetic shifts round toward minus
	// infinity, which is what >>> does on a signed longint.
	function automatic longint heading_q13(longint px, longint py);
		longint vx, vy, ang, sx, sy;
		int i;
		if (px == 0 && py == 0)
			return 0;
		vx = px;
		vy = py;
		ang = 0;
		// A vector in the left half plane is turned by half a turn first.
		if (vx < 0) begin
			ang = (vy >= 0) ? PI_Q16 : -PI_Q16;
			vx = -vx;
			vy = -vy;
		end
		vx = vx * 256;
		vy = vy * 256;
		for (i = 0; i < CORDIC_STEPS; i++) begin
			sx = vy >>> i;
			sy = vx >>> i;
			if (vy > 0) begin
				vx = vx + sx;
				vy = vy - sy;
				ang = ang + ((i < 24) ? ARC_Q16[i] : 0);
			end else begin
				vx = vx - sx;
				vy = vy + sy;
				ang = ang - ((i < 24) ? ARC_Q16[i] : 0);
			end
		end
		ang = (ang + 4) >>> 3;
		if (ang > PI_Q13)
			ang = PI_Q13;
		if (ang < -PI_Q13)
			ang = -PI_Q13;
		return ang;
	endfunction

	// Keeps a copy of the box registers and the per-frame accumulator, and
	// holds the polar fixes that the block still owes us.
	class nearest_board;
		bit            box_on;
		int unsigned   col_lo, col_hi, row_lo, row_hi;
		longint        best_sq;
		longint        best_x, best_y;
		bit            seen;
		polar_t        awaited_fixes[$];
		int            fails;

		function new();
			box_on = 1'b0;
			col_lo = 0;
			col_hi = 0;
			row_lo = 0;
			row_hi = 0;
			fails = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			best_sq = longint'(32'hFFFF_FFFF);
			best_x = 0;
			best_y = 0;
			seen = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
			case (idx)
				CFG_ENABLE:  box_on = val[0];
				CFG_COL_MIN: col_lo = val & 32'h7FF;
				CFG_COL_MAX: col_hi = val & 32'h7FF;
				CFG_ROW_MIN: row_lo = val & 32'h3FF;
				CFG_ROW_MAX: row_hi = val & 32'h3FF;
				default: ;
			endcase
		endfunction

		function int pending();
			return awaited_fixes.size();
		endfunction

		function void note_point(point_t p);
			longint sq, mag;
			polar_t fix;
			// While disabled nothing counts, but a frame end still wipes the frame.
			if (!box_on) begin
				if (p.fend)
					clear_frame();
				return;
			end
			if (p.valid && p.col < MAX_COLS && p.row < MAX_ROWS &&
				p.col > col_lo && p.col < col_hi &&
				p.row >= row_lo && p.row <= row_hi) begin
				sq = longint'(p.x) * longint'(p.x) + longint'(p.y) * longint'(p.y) +
					longint'(p.z) * longint'(p.z);
				// Strictly smaller only: on a tie the earlier point stays.
				if (!seen || sq < best_sq) begin
					best_sq = sq;
					best_x = p.x;
					best_y = p.y;
					seen = 1'b1;
				end
			end
			if (!p.fend)
				return;
			if (!seen) begin
				fix.x = '0;
				fix.y = '0;
				fix.reach = '0;
				fix.heading = '0;
				fix.hit = 1'b0;
			end else begin
				mag = root_floor(best_sq);
				if (mag > 65535)
					mag = 65535;
				fix.x = best_x[COORD_W-1:0];
				fix.y = best_y[COORD_W-1:0];
				fix.reach = mag[RANGE_W-1:0];
				fix.heading = BEAR_W'(heading_q13(best_x, best_y));
				fix.hit = 1'b1;
			end
			awaited_fixes = {awaited_fixes, fix};
			clear_frame();
		endfunction

		function void match(string what, logic signed [16:0] want, logic signed [16:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
				fails++;
			end
		endfunction

		function void check_result(polar_t got);
			polar_t want;
			if (awaited_fixes.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual x %0d y %0d found %0d",
					$time, got.x, got.y, got.hit);
				fails++;
				return;
			end
			want = awaited_fixes.pop_front();
			match("near_x", want.x, got.x);
			match("near_y", want.y, got.y);
			match("near_range", want.reach, got.reach);
			match("near_bearing", want.heading, got.heading);
			match("found", want.hit, got.hit);
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      pt_valid;
	logic                      pt_stall;
	logic [COL_W-1:0]          pixel_col;
	logic [ROW_W-1:0]          pixel_row;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic                      point_valid;
	logic                      frame_end;
	logic                      res_valid;
	logic                      res_stall;
	logic signed [COORD_W-1:0] near_x;
	logic signed [COORD_W-1:0] near_y;
	logic [RANGE_W-1:0]        near_range;
	logic signed [BEAR_W-1:0]  near_bearing;
	logic                      found;

	// Knobs for the two sides: random gaps from the sender, random stalls from
	// the receiver, and a one-shot request for a long receiver hold-off.
	bit          idle_on = 1'b1;
	bit          stall_on = 1'b1;
	bit          hold_results = 1'b0;
	int unsigned cycles = 0;

	// The box currently programmed, so that stimulus can aim inside it.
	int unsigned cur_cmin, cur_cmax, cur_rmin, cur_rmax;

	nearest_board board;

	roi_nearest_point_polar_top #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.point_valid(point_valid),
		.frame_end(frame_end),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.near_x(near_x),
		.near_y(near_y),
		.near_range(near_range),
		.near_bearing(near_bearing),
		.found(found)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a run that stops making progress ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Point beats are picked up at the edge where they are accepted. All bench
	// inputs change by nonblocking assignment, so the values seen here are the
	// ones the block samples at this same edge.
	always @(posedge clk) begin
		point_t seen_pt;
		if (arst_n && pt_valid && !pt_stall) begin
			seen_pt.col = pixel_col;
			seen_pt.row = pixel_row;
			seen_pt.x = point_x;
			seen_pt.y = point_y;
			seen_pt.z = point_z;
			seen_pt.valid = point_valid;
			seen_pt.fend = frame_end;
			board.note_point(seen_pt);
		end
	end

	// Result beats are checked against the oldest outstanding fix.
	always @(posedge clk) begin
		polar_t got;
		if (arst_n && res_valid && !res_stall) begin
			got.x = near_x;
			got.y = near_y;
			got.reach = near_range;
			got.heading = near_bearing;
			got.hit = found;
			board.check_result(got);
		end
	end

	// Receiver side. Besides the short random stalls it can hold off for a long
	// stretch on request; that stretch is counted here, independent of the
	// sender, which keeps offering points until the block backs up.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results) begin
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_results = 1'b0;
				res_stall <= 1'b0;
			end else if (stall_on && $urandom_range(0, 4) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				res_stall <= 1'b0;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	function automatic point_t make_point(int unsigned col, int unsigned row,
		int px, int py, int pz, bit valid, bit fend);
		point_t p;
		p.col = col[COL_W-1:0];
		p.row = row[ROW_W-1:0];
		p.x = px[COORD_W-1:0];
		p.y = py[COORD_W-1:0];
		p.z = pz[COORD_W-1:0];
		p.valid = valid;
		p.fend = fend;
		return p;
	endfunction

	// Coordinates: full random words for bit coverage, plus clusters of small,
	// mid-sized and extreme values so that the nearest point is not always tiny.
	function automatic logic signed [COORD_W-1:0] rand_coord();
		logic signed [COORD_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = COORD_W'($urandom());
			1: v = COORD_W'($signed($urandom_range(0, 4000)) - 2000);
			2: begin
				case ($urandom_range(0, 4))
					0: v = 16'sh8000;
					1: v = 16'sh7FFF;
					2: v = 16'sh0000;
					3: v = -16'sd1;
					default: v = 16'sd1;
				endcase
			end
			default: v = COORD_W'($signed($urandom_range(0, 20000)) - 10000);
		endcase
		return v;
	endfunction

	// Most points fall inside the programmed box so frames usually find
	// something; the rest land anywhere in the image.
	function automatic point_t random_point();
		point_t p;
		if ($urandom_range(0, 9) < 8 && cur_cmax > cur_cmin + 1)
			p.col = COL_W'($urandom_range(cur_cmin + 1, cur_cmax - 1));
		else
			p.col = COL_W'($urandom_range(0, MAX_COLS - 1));
		if ($urandom_range(0, 9) < 8 && cur_rmax >= cur_rmin)
			p.row = ROW_W'($urandom_range(cur_rmin, cur_rmax));
		else
			p.row = ROW_W'($urandom_range(0, MAX_ROWS - 1));
		p.x = rand_coord();
		p.y = rand_coord();
		p.z = rand_coord();
		p.valid = ($urandom_range(0, 9) != 0);
		p.fend = 1'b0;
		return p;
	endfunction

	// Offers one point beat and returns at the edge where it is accepted.
	// It is entered at a clock edge; valid stays high into the next call
	// unless a gap is inserted, so back-to-back beats follow without a pause.
	task automatic send_point(input point_t p);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			pt_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		pt_valid <= 1'b1;
		pixel_col <= p.col;
		pixel_row <= p.row;
		point_x <= p.x;
		point_y <= p.y;
		point_z <= p.z;
		point_valid <= p.valid;
		frame_end <= p.fend;
		@(posedge clk);
		while (pt_stall)
			@(posedge clk);
	endtask

	// Stops offering points, waits until the last accepted beat has been noted,
	// waits for every owed fix to arrive, then lets the block finish whatever
	// point it may still be chewing on.
	task automatic settle();
		pt_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reprograms all five box registers on an idle block.
	task automatic set_box(input bit en, input int unsigned cmin, input int unsigned cmax,
		input int unsigned rmin, input int unsigned rmax);
		logic [CFG_IDX_W-1:0] regs [5];
		int unsigned vals [5];
		int i;
		regs = '{CFG_ENABLE, CFG_COL_MIN, CFG_COL_MAX, CFG_ROW_MIN, CFG_ROW_MAX};
		vals = '{en, cmin, cmax, rmin, rmax};
		settle();
		for (i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i][CFG_DATA_W-1:0];
			@(posedge clk);
			board.write_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
		cur_cmin = cmin;
		cur_cmax = cmax;
		cur_rmin = rmin;
		cur_rmax = rmax;
	endtask

	task automatic random_box(input bit en, input bit narrow);
		int unsigned a, b, c, d;
		if (narrow) begin
			a = $urandom_range(0, MAX_COLS - 3);
			b = a + $urandom_range(2, 40);
			c = $urandom_range(0, MAX_ROWS - 1);
			d = c + $urandom_range(0, 20);
			if (b > MAX_COLS - 1)
				b = MAX_COLS - 1;
			if (d > MAX_ROWS - 1)
				d = MAX_ROWS - 1;
		end else begin
			a = $urandom_range(0, MAX_COLS - 1);
			b = $urandom_range(0, MAX_COLS - 1);
			c = $urandom_range(0, MAX_ROWS - 1);
			d = $urandom_range(0, MAX_ROWS - 1);
			if (a > b) begin
				a = a ^ b;
				b = a ^ b;
				a = a ^ b;
			end
			if (c > d) begin
				c = c ^ d;
				d = c ^ d;
				c = c ^ d;
			end
		end
		set_box(en, a, b, c, d);
	endtask

	// Sends short frames until about count points have gone out. The last point
	// always closes a frame; now and then a frame end also cuts a frame short.
	task automatic random_frames(input int count, input int max_len);
		point_t p;
		int sent, flen, k;
		sent = 0;
		while (sent < count) begin
			flen = $urandom_range(1, max_len);
			for (k = 0; k < flen; k++) begin
				p = random_point();
				p.fend = (k == flen - 1) || ($urandom_range(0, 15) == 0);
				send_point(p);
			end
			sent += flen;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENABLE;
		cfg_data = '0;
		pt_valid = 1'b0;
		pixel_col = '0;
		pixel_row = '0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		point_valid = 1'b0;
		frame_end = 1'b0;
		cur_cmin = 0;
		cur_cmax = 0;
		cur_rmin = 0;
		cur_rmax = 0;
		board = new();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Full box first: columns 1 to 2046, every row.
		set_box(1'b1, 0, MAX_COLS - 1, 0, MAX_ROWS - 1);
		// Columns equal to either bound sit outside; then a 3-4-5 point.
		send_point(make_point(0, 5, 100, 100, 100, 1, 0));
		send_point(make_point(2047, 1023, -32768, -32768, -32768, 1, 0));
		send_point(make_point(1, 0, 3, 4, 0, 1, 1));
		// A frame holding only a NaN point finds nothing.
		send_point(make_point(100, 100, 0, 0, 0, 0, 1));
		// Most negative corner in the last column and row; the NaN closer point
		// that ends the frame must not displace it.
		send_point(make_point(2046, 1023, -32768, -32768, -32768, 1, 0));
		send_point(make_point(700, 300, 1, 1, 1, 0, 1));
		// On the z axis, so x and y are both zero and the bearing is zero.
		send_point(make_point(10, 10, 0, 0, 1234, 1, 1));
		// Negative x on the x axis gives a bearing of plus pi.
		send_point(make_point(10, 10, -500, 0, 0, 1, 1));
		// Equal ranges: the first point of the frame wins.
		send_point(make_point(20, 11, 10, 0, 0, 1, 0));
		send_point(make_point(21, 12, -10, 0, 0, 1, 1));
		send_point(make_point(30, 13, 32767, -32768, 0, 1, 1));
		send_point(make_point(31, 14, 0, -700, 5, 1, 1));
		send_point(make_point(32, 15, -1, 1, -32768, 1, 1));
		// Leave a point pending, disable, and end the frame while disabled: the
		// pending point is dropped and no result comes out.
		send_point(make_point(33, 16, 25, 25, 25, 1, 0));
		set_box(1'b0, 0, MAX_COLS - 1, 0, MAX_ROWS - 1);
		send_point(make_point(40, 40, 1, 2, 3, 1, 0));
		send_point(make_point(41, 41, 5, 5, 5, 1, 1));
		set_box(1'b1, 0, MAX_COLS - 1, 0, MAX_ROWS - 1);
		send_point(make_point(50, 50, 9, 9, 9, 0, 1));
		// One-column, one-row box: rows are inclusive, columns exclusive.
		set_box(1'b1, 99, 101, 7, 7);
		send_point(make_point(100, 7, 300, 400, 0, 1, 0));
		send_point(make_point(100, 8, 1, 1, 1, 1, 0));
		send_point(make_point(99, 7, 1, 1, 1, 1, 0));
		send_point(make_point(101, 7, 1, 1, 1, 1, 1));
		// Inverted column bounds, then inverted row bounds: nothing ever counts.
		set_box(1'b1, 1000, 900, 0, MAX_ROWS - 1);
		send_point(make_point(950, 5, 1, 1, 1, 1, 1));
		set_box(1'b1, 0, MAX_COLS - 1, 600, 500);
		send_point(make_point(5, 550, 1, 1, 1, 1, 1));

		// Random part, one box setting per phase.
		random_box(1'b1, 1'b0);
		random_frames(60, 8);

		set_box(1'b1, 0, MAX_COLS - 1, 0, MAX_ROWS - 1);
		random_frames(60, 8);

		// A stretch with neither gaps nor stalls.
		idle_on = 1'b0;
		stall_on = 1'b0;
		random_box(1'b1, 1'b0);
		random_frames(50, 6);
		idle_on = 1'b1;
		stall_on = 1'b1;

		// Box bounds as after reset, but enabled: empty column range, every frame empty.
		set_box(1'b1, 0, 0, 0, 0);
		random_frames(30, 4);

		random_box(1'b0, 1'b0);
		random_frames(20, 4);

		random_box(1'b1, 1'b1);
		random_frames(60, 8);

		// Long receiver hold-off while the sender keeps pushing short frames, so
		// results pile up and the block has to stall its point input.
		set_box(1'b1, 0, MAX_COLS - 1, 0, MAX_ROWS - 1);
		idle_on = 1'b0;
		hold_results = 1'b1;
		random_frames(40, 2);
		idle_on = 1'b1;

		random_box(1'b1, 1'b0);
		random_frames(60, 8);

		// Closing stretch at full rate on both sides.
		idle_on = 1'b0;
		stall_on = 1'b0;
		random_box(1'b1, 1'b0);
		random_frames(60, 8);

		pt_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (board.fails == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/roi_np_pkg.sv
rtl/roi_np_dist.sv
rtl/roi_np_isqrt.sv
rtl/roi_np_cordic.sv
rtl/roi_nearest_point_polar_top.sv
bench/roi_nearest_point_polar_tb.sv
